/* hdl/mfqs_pkg.sv */
// shared types and constants for the sliding median filter with quadratic scaling
// no dependencies; imported by mfqs_cell, median_filter_quadratic_scaler and the testbench
package mfqs_pkg;

    localparam int WINDOW      = 5;
    localparam int SAMPLE_BITS = 12;
    localparam int GAIN_W      = 16;
    localparam int CONC_W      = 16;
    localparam int Q_SHIFT     = 24;

    localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int MED_IDX = WINDOW / 2;
    localparam int SQ_W    = 2 * SAMPLE_BITS;
    localparam int OPB_W   = (SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W;
    localparam int PROD_W  = SQ_W + OPB_W;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(15043);
    localparam logic [CONC_W-1:0] CONC_MAX   = '1;

    typedef logic [SAMPLE_BITS-1:0]             t_sample;
    typedef logic [WINDOW-1:0][SAMPLE_BITS-1:0] t_window;
    typedef logic [IDX_W-1:0]                   t_idx;
    typedef logic [GAIN_W-1:0]                  t_gain;
    typedef logic [CONC_W-1:0]                  t_conc;
    typedef logic [PROD_W-1:0]                  t_prod;

endpackage

/* hdl/median_filter_quadratic_scaler.sv */
// Sliding five-sample median filter with quadratic scaling. The cell row shifts
// at the edge that accepts a request; the sequencer then steps through median
// select, square, gain multiply and result load. One multiplier is shared by
// the square and the gain step, so these steps run one after another; the next
// request is taken only once the sequencer is back in idle, not while one is in
// flight, while the last result may still wait to be taken. A result
// that is not taken holds the sequencer in its load step and stalls the input.
// The window cells clear to zero at reset, the gain to 15043.
// depends on mfqs_pkg and mfqs_cell
module median_filter_quadratic_scaler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mfqs_pkg::t_sample i_adc_code,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mfqs_pkg::t_sample o_median_code,
    output mfqs_pkg::t_conc   o_concentration,
    input  logic              i_gain_we,
    input  mfqs_pkg::t_gain   i_gain_q24
);
    import mfqs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MED,
        S_SQ,
        S_GAIN,
        S_DONE
    } t_state;

    t_state  r_state;
    t_gain   r_gain;
    t_sample r_med;
    t_prod   r_prod;
    logic    r_out_valid;
    t_sample r_out_med;
    t_conc   r_out_conc;

    logic                          accept;
    t_window                       vals;
    logic    [WINDOW-1:0]          med_flags;
    t_sample                       med_sel;
    logic    [SQ_W-1:0]            op_a;
    logic    [OPB_W-1:0]           op_b;
    t_prod                         mult;
    t_prod                         shifted;
    t_conc                         conc;
    logic                          out_free;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // cell row: new sample enters cell 0, the oldest falls off the far end
    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        t_sample d;
        if (k == 0) begin : g_head
            assign d = i_adc_code;
        end else begin : g_link
            assign d = vals[k-1];
        end
        mfqs_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (accept),
            .i_d      (d),
            .i_vals   (vals),
            .i_idx    (t_idx'(k)),
            .o_q      (vals[k]),
            .o_is_med (med_flags[k])
        );
    end

    always_comb begin
        med_sel = '0;
        for (int k = 0; k < WINDOW; k++) begin
            if (med_flags[k]) begin
                med_sel = med_sel | vals[k];
            end
        end
    end

    // shared multiplier: median squared, then square times gain
    always_comb begin
        if (r_state == S_SQ) begin
            op_a = SQ_W'(r_med);
            op_b = OPB_W'(r_med);
        end else begin
            op_a = r_prod[SQ_W-1:0];
            op_b = OPB_W'(r_gain);
        end
        mult    = PROD_W'(op_a) * PROD_W'(op_b);
        shifted = r_prod >> Q_SHIFT;
        conc    = (shifted > PROD_W'(CONC_MAX)) ? CONC_MAX : shifted[CONC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gain      <= GAIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_gain_we) begin
                r_gain <= i_gain_q24;
            end
            // the load step sets valid itself when the old result leaves
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_MED;
                    end
                end
                S_MED: begin
                    r_med   <= med_sel;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_prod  <= mult;
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    r_prod  <= mult;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_med   <= r_med;
                        r_out_conc  <= conc;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_median_code   = r_out_med;
    assign o_concentration = r_out_conc;

    // exactly one cell holds the median rank
    a_one_median: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MED) |-> $onehot(med_flags))
        else $error("median select is not one-hot");

    // a result appears only from the load step
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result valid without a finished request");

    // an accepted request moves straight to median select
    a_accept_to_med: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_MED))
        else $error("accepted request did not start");

    // a pending result is never overwritten while stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_conc)))
        else $error("stalled result was overwritten");

endmodule

/* hdl/mfqs_cell.sv */
// one window cell: holds a sample, hands it to its neighbour on each request,
// and flags itself when its rank in the window is the median. depends on mfqs_pkg
module mfqs_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  mfqs_pkg::t_sample i_d,
    input  mfqs_pkg::t_window i_vals,
    input  mfqs_pkg::t_idx    i_idx,
    output mfqs_pkg::t_sample o_q,
    output logic              o_is_med
);
    import mfqs_pkg::*;

    t_sample r_q;
    t_idx    rank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    // rank = smaller entries, plus equal entries in lower cells (ties broken by position)
    always_comb begin
        rank = '0;
        for (int j = 0; j < WINDOW; j++) begin
            if ((i_vals[j] < r_q) || ((i_vals[j] == r_q) && (j < int'(i_idx)))) begin
                rank = rank + t_idx'(1);
            end
        end
    end

    assign o_q      = r_q;
    assign o_is_med = (rank == t_idx'(MED_IDX));

endmodule

/* test/median_filter_quadratic_scaler_tb.sv */
// self-checking testbench for the sliding median filter with quadratic scaling
// predicts median and concentration per request from its own ring copy and gain;
// depends on mfqs_pkg and the median_filter_quadratic_scaler rtl
`timescale 1ns / 1ps

module median_filter_quadratic_scaler_tb;

    import mfqs_pkg::*;

    typedef struct packed {
        t_sample median;
        t_conc   conc;
    } t_reading;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_ALTERNATE,
        STALL_HEAVY
    } t_stall_mode;

    logic    i_clk         = 1'b0;
    logic    i_rst_n       = 1'b0;
    logic    i_in_valid    = 1'b0;
    t_sample i_adc_code    = '0;
    logic    i_out_stall   = 1'b0;
    logic    i_gain_we     = 1'b0;
    t_gain   i_gain_q24    = '0;
    logic    o_in_stall;
    logic    o_out_valid;
    t_sample o_median_code;
    t_conc   o_concentration;

    // predictor state
    t_sample ring [WINDOW] = '{default: '0};
    int      ring_slot     = 0;
    t_gain   gain_now      = GAIN_RESET;

    t_sample  pending_codes [$];
    t_reading due_readings  [$];
    int       codes_issued  = 0;
    int       codes_taken   = 0;
    int       mismatches    = 0;
    logic     in_fire       = 1'b0;

    // sender burst shaping
    int burst_left = 8;
    int gap_left   = 0;

    // receiver stall shaping
    t_stall_mode stall_mode = STALL_NONE;
    int          seg_left   = 0;
    int          hold_left  = 0;
    logic        hold_done  = 1'b0;

    median_filter_quadratic_scaler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_adc_code      (i_adc_code),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_median_code   (o_median_code),
        .o_concentration (o_concentration),
        .i_gain_we       (i_gain_we),
        .i_gain_q24      (i_gain_q24)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // new code replaces the oldest entry, median of the ring, then square and gain
    function automatic t_reading absorb_code(input t_sample code);
        t_sample     sorted [WINDOW];
        t_sample     v;
        int          i;
        int          j;
        logic [63:0] prod;
        t_reading    r;
        ring[ring_slot] = code;
        ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
        for (i = 0; i < WINDOW; i++) begin
            sorted[i] = ring[i];
        end
        for (i = 1; i < WINDOW; i++) begin
            v = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        r.median = sorted[MED_IDX];
        prod = (64'(r.median) * 64'(r.median) * 64'(gain_now)) >> Q_SHIFT;
        r.conc = (prod > 64'(CONC_MAX)) ? CONC_MAX : t_conc'(prod);
        return r;
    endfunction

    // monitor and predictor
    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            if (i_gain_we) begin
                gain_now = i_gain_q24;
            end
            if (o_out_valid && !i_out_stall) begin
                if (due_readings.size() == 0) begin
                    flag_mismatch("result with nothing due", int'(o_median_code), 0);
                end else begin
                    want = due_readings.pop_front();
                    if (o_median_code !== want.median) begin
                        flag_mismatch("median_code", int'(o_median_code),
                                      int'(want.median));
                    end
                    if (o_concentration !== want.conc) begin
                        flag_mismatch("concentration", int'(o_concentration),
                                      int'(want.conc));
                    end
                end
            end
            in_fire <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                due_readings.push_back(absorb_code(i_adc_code));
                codes_taken++;
            end
        end
    end

    // driver: a request stays up until taken, then the next one or a gap
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_codes.size() > 0) begin
                i_in_valid <= 1'b1;
                i_adc_code <= pending_codes.pop_front();
                codes_issued++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: changing stall patterns plus one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && codes_taken >= 200) begin
            hold_done = 1'b1;
            hold_left = 120;
            i_out_stall <= 1'b1;
        end else begin
            if (seg_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                seg_left = $urandom_range(10, 150);
            end
            seg_left--;
            case (stall_mode)
                STALL_NONE:      i_out_stall <= 1'b0;
                STALL_LIGHT:     i_out_stall <= ($urandom_range(0, 2) == 0);
                STALL_ALTERNATE: i_out_stall <= ~i_out_stall;
                default:         i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_codes.size() != 0 || codes_issued != codes_taken
               || due_readings.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_gain(input t_gain g);
        @(negedge i_clk);
        i_gain_we  <= 1'b1;
        i_gain_q24 <= g;
        @(negedge i_clk);
        i_gain_we  <= 1'b0;
    endtask

    // sensor-like trace: drifting level, full-range noise, spikes and steps
    task automatic queue_sensor_trace(input int n);
        int level;
        int k;
        int pick;
        level = $urandom_range(0, 4095);
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                pending_codes.push_back(t_sample'($urandom));
            end else if (pick < 8) begin
                level = level + $urandom_range(0, 64) - 32;
                if (level < 0) level = 0;
                if (level > 4095) level = 4095;
                pending_codes.push_back(t_sample'(level));
            end else if (pick == 8) begin
                pending_codes.push_back($urandom_range(0, 1) ? t_sample'(4095) : t_sample'(0));
            end else begin
                level = $urandom_range(0, 4095);
                pending_codes.push_back(t_sample'(level));
            end
        end
    endtask

    initial begin
        t_gain gains [6];
        int    p;
        int    k;
        gains = '{16'hFFFF, 16'h0000, 16'h0001, GAIN_RESET,
                  t_gain'($urandom), t_gain'($urandom_range(30000, 65535))};

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // start-up zeros still in the ring, then extremes and bit patterns
        pending_codes = '{12'd0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                          12'd0, 12'd0, 12'h555, 12'hAAA, 12'd1, 12'hFFE,
                          12'h800, 12'h7FF, 12'hFFF, 12'd100, 12'd100, 12'hFFF,
                          12'd100, 12'd0, 12'd100};
        wait_drained();

        for (p = 0; p < 6; p++) begin
            write_gain(gains[p]);
            // full-scale median against each gain
            for (k = 0; k < 5; k++) begin
                pending_codes.push_back(12'hFFF);
            end
            queue_sensor_trace(310);
            wait_drained();
        end

        repeat (10) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
